>>> rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// PWM divider and compare package
// Shared widths, constants, accuracy codes and the divider request and
// response types.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] FREQ_LIMIT_DIV = 32'd100;
  localparam logic [DIV_W-1:0] PRESCALER_MAX  = 32'd65535;
  localparam logic [DIV_W-1:0] DUTY_DIV       = 32'd1000;
  localparam logic [15:0]      PERIOD_FINE    = 16'd1000;
  localparam logic [15:0]      PERIOD_COARSE  = 16'd100;
  localparam logic [15:0]      DUTY_FULL      = 16'd1000;

  localparam logic [1:0] ACC_NONE   = 2'd0;
  localparam logic [1:0] ACC_FINE   = 2'd1;
  localparam logic [1:0] ACC_COARSE = 2'd2;

  localparam logic CFG_BUS_CLOCK = 1'b0;
  localparam logic CFG_BUS_DIV   = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/pdc_divider.sv
// ----------------------------------------------------------------------------
// PWM divider and compare: shared divider
// Radix-2 restoring divider, one quotient bit per cycle, with a one-cycle
// done pulse carrying the quotient.
// ----------------------------------------------------------------------------
module pdc_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  pdc_pkg::div_req_t req,
  output pdc_pkg::div_rsp_t rsp
);

  logic [pdc_pkg::DIV_W-1:0] dvd_r;
  logic [pdc_pkg::DIV_W-1:0] dvs_r;
  logic [pdc_pkg::DIV_W-1:0] rem_r;
  logic [pdc_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [pdc_pkg::DIV_W:0]   trial;
  logic [pdc_pkg::DIV_W:0]   diff;

  assign trial = {rem_r, dvd_r[pdc_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        if (!diff[pdc_pkg::DIV_W]) begin
          rem_r <= diff[pdc_pkg::DIV_W-1:0];
          dvd_r <= {dvd_r[pdc_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[pdc_pkg::DIV_W-1:0];
          dvd_r <= {dvd_r[pdc_pkg::DIV_W-2:0], 1'b0};
        end
        cnt_r  <= cnt_r + 1'b1;
        busy_r <= (cnt_r != pdc_pkg::CNT_W'(pdc_pkg::DIV_W - 1));
        done_r <= (cnt_r == pdc_pkg::CNT_W'(pdc_pkg::DIV_W - 1));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

>>> rtl/pwm_divider_and_compare_calc.sv
// ----------------------------------------------------------------------------
// PWM divider and compare calculator
// Finds the timer prescaler, period and compare value for a wanted PWM
// frequency and duty, using one shared divider under a small sequencer.
// ----------------------------------------------------------------------------
// One item takes five to seven divisions on the shared radix-2 divider, one
// after another, so the divider's one quotient bit per cycle sets the pace
// while the output register is free. The block takes no new item until the
// current result has been moved into the output register, which then waits
// for the consumer independently.
module pwm_divider_and_compare_calc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_frequency_hz,
  input  logic [15:0] in_duty_permille,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_prescaler_setting,
  output logic [15:0] out_period_count,
  output logic [15:0] out_compare_count,
  output logic [1:0]  out_accuracy_code,
  output logic        out_frequency_clamped
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FMAX = 4'd1;
  localparam logic [3:0] S_PRE  = 4'd2;
  localparam logic [3:0] S_PER1 = 4'd3;
  localparam logic [3:0] S_PER2 = 4'd4;
  localparam logic [3:0] S_NF1  = 4'd5;
  localparam logic [3:0] S_NF2  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [30:0] bus_clock_r;
  logic        bus_div_r;
  logic [3:0]  state_r;
  logic [31:0] freq_r;
  logic [9:0]  duty_r;
  logic [15:0] setting_r;
  logic [15:0] period_r;
  logic [15:0] compare_r;
  logic [1:0]  acc_r;
  logic        clamped_r;
  logic        out_valid_r;

  pdc_pkg::div_req_t div_req_r;
  pdc_pkg::div_rsp_t div_rsp;

  logic [31:0] clk_hz;
  logic [31:0] quo;
  logic [31:0] fmax;
  logic [31:0] freq_in;
  logic [31:0] freq_use;
  logic        clamp_now;
  logic [25:0] duty_prod;
  logic        div_start_nxt;

  assign clk_hz    = bus_div_r ? {bus_clock_r, 1'b0} : {1'b0, bus_clock_r};
  assign quo       = div_rsp.quotient;
  assign fmax      = (quo == 32'd0) ? 32'd1 : quo;
  assign freq_in   = (freq_r == 32'd0) ? 32'd1 : freq_r;
  assign clamp_now = freq_in > fmax;
  assign freq_use  = clamp_now ? fmax : freq_in;
  assign duty_prod = duty_r * quo[15:0];

  assign div_start_nxt = (state_r == S_IDLE) ? in_valid :
                         (div_rsp.done &&
                          (state_r inside {S_FMAX, S_PRE, S_PER1, S_PER2, S_NF1, S_NF2}));

  pdc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_clock_r <= 31'd48000000;
      bus_div_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pdc_pkg::CFG_BUS_CLOCK: bus_clock_r <= cfg_wdata;
        pdc_pkg::CFG_BUS_DIV:   bus_div_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      div_req_r.start <= div_start_nxt;
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            freq_r             <= in_frequency_hz;
            duty_r             <= (in_duty_permille > pdc_pkg::DUTY_FULL) ?
                                  pdc_pkg::DUTY_FULL[9:0] : in_duty_permille[9:0];
            div_req_r.dividend <= clk_hz;
            div_req_r.divisor  <= pdc_pkg::FREQ_LIMIT_DIV;
            state_r            <= S_FMAX;
          end
        end
        S_FMAX: begin
          if (div_rsp.done) begin
            freq_r             <= freq_use;
            clamped_r          <= clamp_now;
            div_req_r.dividend <= {16'd0, clk_hz[31:16]};
            div_req_r.divisor  <= freq_use;
            state_r            <= S_PRE;
          end
        end
        S_PRE: begin
          if (div_rsp.done) begin
            div_req_r.dividend <= clk_hz;
            if (quo < pdc_pkg::PRESCALER_MAX) begin
              setting_r         <= quo[15:0];
              div_req_r.divisor <= {16'd0, quo[15:0] + 16'd1};
              state_r           <= S_PER1;
            end else begin
              div_req_r.divisor <= pdc_pkg::PRESCALER_MAX;
              state_r           <= S_NF1;
            end
          end
        end
        S_PER1: begin
          if (div_rsp.done) begin
            div_req_r.dividend <= quo;
            div_req_r.divisor  <= freq_r;
            state_r            <= S_PER2;
          end
        end
        S_PER2: begin
          if (div_rsp.done) begin
            if (quo >= {16'd0, pdc_pkg::PERIOD_FINE} ||
                quo >= {16'd0, pdc_pkg::PERIOD_COARSE}) begin
              acc_r              <= (quo >= {16'd0, pdc_pkg::PERIOD_FINE}) ?
                                    pdc_pkg::ACC_FINE : pdc_pkg::ACC_COARSE;
              period_r           <= quo[15:0];
              div_req_r.dividend <= {6'd0, duty_prod};
              div_req_r.divisor  <= pdc_pkg::DUTY_DIV;
              state_r            <= S_CMP;
            end else begin
              div_req_r.dividend <= clk_hz;
              div_req_r.divisor  <= pdc_pkg::PRESCALER_MAX;
              state_r            <= S_NF1;
            end
          end
        end
        S_NF1: begin
          if (div_rsp.done) begin
            div_req_r.dividend <= quo;
            div_req_r.divisor  <= freq_r;
            state_r            <= S_NF2;
          end
        end
        S_NF2: begin
          if (div_rsp.done) begin
            acc_r              <= pdc_pkg::ACC_NONE;
            setting_r          <= pdc_pkg::PRESCALER_MAX[15:0];
            period_r           <= quo[15:0];
            div_req_r.dividend <= {6'd0, duty_prod};
            div_req_r.divisor  <= pdc_pkg::DUTY_DIV;
            state_r            <= S_CMP;
          end
        end
        S_CMP: begin
          if (div_rsp.done) begin
            compare_r <= quo[15:0];
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_prescaler_setting <= setting_r;
            out_period_count      <= period_r;
            out_compare_count     <= compare_r;
            out_accuracy_code     <= acc_r;
            out_frequency_clamped <= clamped_r;
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted but sequencer stayed idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req_r.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_acc_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_accuracy_code != 2'd3)
    else $error("illegal accuracy code");

  a_no_fit_setting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accuracy_code == pdc_pkg::ACC_NONE |->
      out_prescaler_setting == pdc_pkg::PRESCALER_MAX[15:0])
    else $error("no-fit result without maximum prescaler");

  a_fine_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accuracy_code == pdc_pkg::ACC_FINE |->
      out_period_count >= pdc_pkg::PERIOD_FINE)
    else $error("fine accuracy with short period");

endmodule

>>> test/pwm_divider_and_compare_calc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM divider and compare calculator testbench
// Drives frequency and duty items through the block under several bus clock
// settings, predicts each prescaler, period, compare, accuracy code and clamp
// flag in the bench or from a directed row, and checks every result in order.
// ----------------------------------------------------------------------------
module pwm_divider_and_compare_calc_test;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DRAIN_CYCLES   = 300;
  localparam logic [63:0] PERIOD_SPAN    = 64'd65536;

  typedef struct packed {
    logic [15:0] prescaler;
    logic [15:0] period;
    logic [15:0] compare;
    logic [1:0]  accuracy;
    logic        clamped;
  } pwm_setting_t;

  typedef struct packed {
    logic         is_cfg;
    logic         cfg_idx;
    logic [30:0]  cfg_val;
    logic [31:0]  freq;
    logic [15:0]  duty;
    logic         typed;
    pwm_setting_t want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = pdc_pkg::CFG_BUS_CLOCK;
  logic [30:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_frequency_hz = '0;
  logic [15:0] in_duty_permille = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_prescaler_setting;
  logic [15:0] out_period_count;
  logic [15:0] out_compare_count;
  logic [1:0]  out_accuracy_code;
  logic        out_frequency_clamped;

  logic [30:0]  model_bus_clock = 31'd48000000;
  logic         model_bus_divided = 1'b0;
  logic         steady = 1'b0;
  int           mismatch_count = 0;
  pwm_setting_t expected_settings[$];
  step_t        directed_steps[$];

  always #4 clk = ~clk;

  pwm_divider_and_compare_calc u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_frequency_hz       (in_frequency_hz),
    .in_duty_permille      (in_duty_permille),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_prescaler_setting (out_prescaler_setting),
    .out_period_count      (out_period_count),
    .out_compare_count     (out_compare_count),
    .out_accuracy_code     (out_accuracy_code),
    .out_frequency_clamped (out_frequency_clamped)
  );

  function automatic logic [63:0] timer_clock_hz();
    logic [63:0] tclk;
    tclk = {33'd0, model_bus_clock};
    if (model_bus_divided) begin
      tclk = tclk * 2;
    end
    return tclk;
  endfunction

  function automatic pwm_setting_t predict_pwm_setting(logic [31:0] freq, logic [15:0] duty);
    logic [63:0]  tclk;
    logic [63:0]  fmax;
    logic [63:0]  f;
    logic [63:0]  p;
    logic [63:0]  period;
    logic [63:0]  duty_eff;
    logic [63:0]  product;
    logic [63:0]  divider;
    pwm_setting_t r;
    tclk = timer_clock_hz();
    fmax = tclk / pdc_pkg::FREQ_LIMIT_DIV;
    if (fmax == 0) begin
      fmax = 1;
    end
    f = {32'd0, freq};
    if (f == 0) begin
      f = 1;
    end
    r.clamped = 1'b0;
    if (f > fmax) begin
      f = fmax;
      r.clamped = 1'b1;
    end
    // The period only falls as the prescaler grows, so the first prescaler
    // that brings it under the counter span is the only one worth testing.
    r.accuracy = pdc_pkg::ACC_NONE;
    period = 0;
    p = tclk / (PERIOD_SPAN * f) + 1;
    if (p <= pdc_pkg::PRESCALER_MAX) begin
      period = tclk / (p * f);
      if (period >= pdc_pkg::PERIOD_FINE) begin
        r.accuracy = pdc_pkg::ACC_FINE;
      end else if (period >= pdc_pkg::PERIOD_COARSE) begin
        r.accuracy = pdc_pkg::ACC_COARSE;
      end
    end
    if (r.accuracy == pdc_pkg::ACC_NONE) begin
      p = PERIOD_SPAN;
      period = tclk / ({32'd0, pdc_pkg::PRESCALER_MAX} * f);
    end
    duty_eff = (duty > pdc_pkg::DUTY_FULL) ? {48'd0, pdc_pkg::DUTY_FULL} : {48'd0, duty};
    divider = p - 1;
    product = (duty_eff * {48'd0, period[15:0]}) / pdc_pkg::DUTY_DIV;
    r.prescaler = divider[15:0];
    r.period = period[15:0];
    r.compare = product[15:0];
    return r;
  endfunction

  function automatic step_t item_row(logic [31:0] f, logic [15:0] d);
    step_t s;
    s = '0;
    s.freq = f;
    s.duty = d;
    return s;
  endfunction

  function automatic step_t typed_row(logic [31:0] f, logic [15:0] d, pwm_setting_t w);
    step_t s;
    s = item_row(f, d);
    s.typed = 1'b1;
    s.want = w;
    return s;
  endfunction

  function automatic step_t cfg_row(logic idx, logic [30:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = v;
    return s;
  endfunction

  function automatic logic [30:0] pick_bus_clock();
    logic [31:0] r;
    case ($urandom_range(0, 5))
      0: r = $urandom_range(0, 99);
      1: r = 32'h7FFF_FFFF;
      2: r = $urandom & 32'h7FFF_FFFF;
      default: r = $urandom_range(100, 200_000_000);
    endcase
    return r[30:0];
  endfunction

  function automatic logic [31:0] pick_frequency();
    logic [63:0] lim;
    logic [31:0] r;
    lim = timer_clock_hz() / pdc_pkg::FREQ_LIMIT_DIV;
    case ($urandom_range(0, 9))
      0: r = $urandom_range(0, 1);
      1, 2, 3: r = $urandom_range(1, 2000);
      4, 5: r = $urandom_range(1, 200_000);
      6, 7: r = lim[31:0] + $urandom_range(0, 4) - 2;
      8: r = $urandom;
      default: r = $urandom >> $urandom_range(0, 31);
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick_duty();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0: r = 0;
      1: r = pdc_pkg::DUTY_FULL;
      2: r = $urandom;
      default: r = $urandom_range(0, 1000);
    endcase
    return r[15:0];
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_settings.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pdc_pkg::CFG_BUS_CLOCK) begin
      model_bus_clock = val;
    end else begin
      model_bus_divided = val[0];
    end
    @(posedge clk);
  endtask

  task automatic send_item(logic [31:0] freq, logic [15:0] duty, logic typed,
                           pwm_setting_t want);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frequency_hz <= freq;
    in_duty_permille <= duty;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_settings.push_back(typed ? want : predict_pwm_setting(freq, duty));
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_monitor
    pwm_setting_t want;
    out_ready <= steady || ($urandom_range(0, 99) >= 25);
    if (rst_n && out_valid && out_ready) begin
      if (expected_settings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result with no item outstanding: prescaler %0d period %0d",
                   out_prescaler_setting, out_period_count);
        end
      end else begin
        want = expected_settings.pop_front();
        check_field("prescaler_setting", want.prescaler, out_prescaler_setting);
        check_field("period_count", want.period, out_period_count);
        check_field("compare_count", want.compare, out_compare_count);
        check_field("accuracy_code", {14'd0, want.accuracy}, {14'd0, out_accuracy_code});
        check_field("frequency_clamped", {15'd0, want.clamped},
                    {15'd0, out_frequency_clamped});
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int    phase;
    int    n;
    step_t row;

    // Reset clock of 48 MHz, no doubling.
    directed_steps.push_back(typed_row(32'd1000, 16'd500,
      '{16'd0, 16'd48000, 16'd24000, pdc_pkg::ACC_FINE, 1'b0}));
    directed_steps.push_back(typed_row(32'd0, 16'd0,
      '{16'd732, 16'd65484, 16'd0, pdc_pkg::ACC_FINE, 1'b0}));
    directed_steps.push_back(typed_row(32'd480000, 16'd1000,
      '{16'd0, 16'd100, 16'd100, pdc_pkg::ACC_COARSE, 1'b0}));
    directed_steps.push_back(typed_row(32'd480001, 16'hFFFF,
      '{16'd0, 16'd100, 16'd100, pdc_pkg::ACC_COARSE, 1'b1}));
    directed_steps.push_back(typed_row(32'hFFFF_FFFF, 16'hFFFF,
      '{16'd0, 16'd100, 16'd100, pdc_pkg::ACC_COARSE, 1'b1}));
    directed_steps.push_back(typed_row(32'd48000, 16'd999,
      '{16'd0, 16'd1000, 16'd999, pdc_pkg::ACC_FINE, 1'b0}));
    directed_steps.push_back(typed_row(32'd48001, 16'd1001,
      '{16'd0, 16'd999, 16'd999, pdc_pkg::ACC_COARSE, 1'b0}));
    directed_steps.push_back(item_row(32'd1, 16'd1));
    directed_steps.push_back(item_row(32'd732, 16'd1));
    directed_steps.push_back(item_row(32'd733, 16'h8000));
    directed_steps.push_back(item_row(32'd5000, 16'h7FFF));
    directed_steps.push_back(item_row(32'h5555_5555, 16'h5555));
    directed_steps.push_back(item_row(32'hAAAA_AAAA, 16'hAAAA));
    // Doubled timer clock.
    directed_steps.push_back(cfg_row(pdc_pkg::CFG_BUS_DIV, 31'd1));
    directed_steps.push_back(item_row(32'd1000, 16'd250));
    directed_steps.push_back(typed_row(32'd960000, 16'd1000,
      '{16'd0, 16'd100, 16'd100, pdc_pkg::ACC_COARSE, 1'b0}));
    // Clock below 100 Hz, and a stopped clock.
    directed_steps.push_back(cfg_row(pdc_pkg::CFG_BUS_DIV, 31'd0));
    directed_steps.push_back(cfg_row(pdc_pkg::CFG_BUS_CLOCK, 31'd50));
    directed_steps.push_back(typed_row(32'd1, 16'd500,
      '{16'hFFFF, 16'd0, 16'd0, pdc_pkg::ACC_NONE, 1'b0}));
    directed_steps.push_back(typed_row(32'd2, 16'd500,
      '{16'hFFFF, 16'd0, 16'd0, pdc_pkg::ACC_NONE, 1'b1}));
    directed_steps.push_back(cfg_row(pdc_pkg::CFG_BUS_CLOCK, 31'd0));
    directed_steps.push_back(item_row(32'd7, 16'd1000));
    // Largest timer clock: no prescaler fits a 1 Hz output.
    directed_steps.push_back(cfg_row(pdc_pkg::CFG_BUS_CLOCK, 31'h7FFF_FFFF));
    directed_steps.push_back(cfg_row(pdc_pkg::CFG_BUS_DIV, 31'd1));
    directed_steps.push_back(typed_row(32'd1, 16'd1000,
      '{16'hFFFF, 16'd0, 16'd0, pdc_pkg::ACC_NONE, 1'b0}));
    directed_steps.push_back(item_row(32'd2, 16'd500));
    directed_steps.push_back(item_row(32'hFFFF_FFFF, 16'd0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_cfg) begin
        wait_drained();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        send_item(row.freq, row.duty, row.typed, row.want);
      end
    end

    for (phase = 0; phase < 5; phase++) begin
      wait_drained();
      write_reg(pdc_pkg::CFG_BUS_CLOCK, pick_bus_clock());
      write_reg(pdc_pkg::CFG_BUS_DIV, 31'($urandom_range(0, 1)));
      steady <= (phase == 2);
      for (n = 0; n < 16; n++) begin
        if (phase == 3 && n == 10) begin
          wait_drained();
        end
        send_item(pick_frequency(), pick_duty(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_settings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> pwm_divider_and_compare_calc.f
rtl/pdc_pkg.sv
rtl/pdc_divider.sv
rtl/pwm_divider_and_compare_calc.sv
test/pwm_divider_and_compare_calc_test.sv
